/* rtl/core/tau_pkg.sv */
// Shared types and constants for the triangle assembly unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package tau_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned NORM_BITS = 31;
    localparam int unsigned FRAC_BITS = 30;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vtx_t;

    typedef struct packed {
        vtx_t p0;
        vtx_t p1;
        vtx_t p2;
    } tri_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
    } res_t;

    // Handshake between queue and back end
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_MAG,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DLOAD,
        ST_DSTEP,
        ST_DONE
    } back_state_t;

endpackage
`default_nettype wire

/* rtl/core/tau_front.sv */
// Front end: collects vertices and forms triangles.
// Depends on tau_pkg.
`default_nettype none
module tau_front
    import tau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire vtx_t s_data,
    output logic      push_valid,
    input  wire logic push_ready,
    output tri_t      push_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    vtx_t       held0_reg;
    vtx_t       held1_reg;
    logic       take;

    // First two corners only store; the third needs queue room
    assign s_ready    = (count_reg != 2'd2) || push_ready;
    assign take       = s_valid && s_ready;
    assign push_valid = s_valid && (count_reg == 2'd2);
    assign push_data  = '{p0: held0_reg, p1: held1_reg, p2: s_data};

    always_comb begin
        count_next = count_reg;
        if (take) begin
            count_next = (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Hold corners
    always_ff @(posedge aclk) begin
        if (take && count_reg == 2'd0) begin
            held0_reg <= s_data;
        end
        if (take && count_reg == 2'd1) begin
            held1_reg <= s_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tau_fifo.sv */
// Two-entry triangle queue between front and back end.
// Depends on tau_pkg.
`default_nettype none
module tau_fifo
    import tau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire tri_t wr_data,
    output hs_t       rd_hs_o,
    input  wire logic rd_ready,
    output tri_t      rd_data
);

    tri_t       mem [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready      = (fill_reg != 2'd2);
    assign rd_hs_o.valid = (fill_reg != 2'd0);
    assign rd_hs_o.ready = rd_ready;
    assign do_wr         = wr_valid && wr_ready;
    assign do_rd         = rd_hs_o.valid && rd_ready;
    assign rd_data       = mem[rptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (do_wr) begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_rd) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tau_back.sv */
// Back end: sequencer that computes the unit face normal and drives results.
// Depends on tau_pkg.
`default_nettype none
module tau_back
    import tau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire hs_t  q_hs_i,
    output logic      q_pop,
    input  wire tri_t q_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    back_state_t state_reg;
    back_state_t state_next;

    tri_t               tri_reg;
    logic signed [32:0] a_reg [3];
    logic signed [32:0] b_reg [3];
    logic signed [66:0] cross_reg [3];
    logic [65:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        root_reg;
    logic [63:0]        bit_reg;
    logic [32:0]        dr_reg;
    logic [30:0]        dn_reg;
    logic [30:0]        quo_reg;
    logic [31:0]        nrm_reg [3];
    logic [4:0]         cnt_reg;
    logic [1:0]         comp_reg;
    logic               out_valid_reg;
    res_t               out_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;
    logic [1:0]         mul_idx;
    logic               any_high;
    logic               any_top;
    logic               all_zero;
    logic [61:0]        sq_prod;
    logic [63:0]        trial;
    logic [61:0]        num;
    logic [32:0]        dtry;
    logic               out_free;

    assign q_pop    = (state_reg == ST_IDLE) && q_hs_i.valid;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // Operand select for the shared multiplier: two products per cross term
    always_comb begin
        mul_idx = 2'd0;
        mul_a   = a_reg[0];
        mul_b   = b_reg[0];
        case (cnt_reg[2:0])
            3'd0: begin mul_idx = 2'd0; mul_a = a_reg[1]; mul_b = b_reg[2]; end
            3'd1: begin mul_idx = 2'd0; mul_a = a_reg[2]; mul_b = b_reg[1]; end
            3'd2: begin mul_idx = 2'd1; mul_a = a_reg[2]; mul_b = b_reg[0]; end
            3'd3: begin mul_idx = 2'd1; mul_a = a_reg[0]; mul_b = b_reg[2]; end
            3'd4: begin mul_idx = 2'd2; mul_a = a_reg[0]; mul_b = b_reg[1]; end
            3'd5: begin mul_idx = 2'd2; mul_a = a_reg[1]; mul_b = b_reg[0]; end
            default: begin mul_idx = 2'd0; mul_a = a_reg[0]; mul_b = b_reg[0]; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Normalization status over the three magnitudes
    assign any_high = (|mag_reg[0][65:NORM_BITS]) || (|mag_reg[1][65:NORM_BITS])
                   || (|mag_reg[2][65:NORM_BITS]);
    assign any_top  = mag_reg[0][NORM_BITS-1] || mag_reg[1][NORM_BITS-1]
                   || mag_reg[2][NORM_BITS-1];
    assign all_zero = (cross_reg[0] == '0) && (cross_reg[1] == '0)
                   && (cross_reg[2] == '0);

    assign sq_prod = mag_reg[comp_reg][30:0] * mag_reg[comp_reg][30:0];
    assign trial   = root_reg + bit_reg;
    assign num     = {mag_reg[comp_reg][30:0], {FRAC_BITS{1'b0}}}
                   + {31'd0, root_reg[31:1]};
    assign dtry    = {dr_reg[31:0], dn_reg[30]};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (q_hs_i.valid) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   if (cnt_reg == 5'd5) state_next = ST_MAG;
            ST_MAG:   state_next = all_zero ? ST_DONE : ST_NORM;
            ST_NORM:  if (!any_high && any_top) state_next = ST_SQ;
            ST_SQ:    if (comp_reg == 2'd2) state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == 5'd31) state_next = ST_DLOAD;
            ST_DLOAD: state_next = ST_DSTEP;
            ST_DSTEP: begin
                if (cnt_reg == 5'd30) begin
                    state_next = (comp_reg == 2'd2) ? ST_DONE : ST_DLOAD;
                end
            end
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                tri_reg  <= q_data;
                cnt_reg  <= 5'd0;
                comp_reg <= 2'd0;
            end
            ST_DIFF: begin
                a_reg[0] <= 33'(tri_reg.p0.vertex_x) - 33'(tri_reg.p1.vertex_x);
                a_reg[1] <= 33'(tri_reg.p0.vertex_y) - 33'(tri_reg.p1.vertex_y);
                a_reg[2] <= 33'(tri_reg.p0.vertex_z) - 33'(tri_reg.p1.vertex_z);
                b_reg[0] <= 33'(tri_reg.p0.vertex_x) - 33'(tri_reg.p2.vertex_x);
                b_reg[1] <= 33'(tri_reg.p0.vertex_y) - 33'(tri_reg.p2.vertex_y);
                b_reg[2] <= 33'(tri_reg.p0.vertex_z) - 33'(tri_reg.p2.vertex_z);
            end
            ST_MUL: begin
                if (!cnt_reg[0]) begin
                    cross_reg[mul_idx] <= 67'(prod);
                end else begin
                    cross_reg[mul_idx] <= cross_reg[mul_idx] - 67'(prod);
                end
                cnt_reg <= (cnt_reg == 5'd5) ? 5'd0 : cnt_reg + 5'd1;
            end
            ST_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= cross_reg[i][66];
                    mag_reg[i] <= cross_reg[i][66] ? 66'(-cross_reg[i])
                                                   : cross_reg[i][65:0];
                    nrm_reg[i] <= 32'd0;
                end
                sum_reg <= 64'd0;
            end
            ST_NORM: begin
                // Shift one bit a cycle until the largest has 31 bits
                for (int i = 0; i < 3; i++) begin
                    if (any_high) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (!any_top) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            ST_SQ: begin
                sum_reg  <= sum_reg + 64'(sq_prod);
                comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                rem_reg  <= sum_reg + 64'(sq_prod);
                root_reg <= 64'd0;
                bit_reg  <= 64'd1 << 62;
                cnt_reg  <= 5'd0;
            end
            ST_SQRT: begin
                // One result bit per cycle
                if (rem_reg >= trial) begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
            end
            ST_DLOAD: begin
                dr_reg  <= {2'b00, num[61:31]};
                dn_reg  <= num[30:0];
                quo_reg <= 31'd0;
                cnt_reg <= 5'd0;
            end
            ST_DSTEP: begin
                // Restoring divide, one quotient bit per cycle
                if (dtry >= {1'b0, root_reg[31:0]}) begin
                    dr_reg  <= dtry - {1'b0, root_reg[31:0]};
                    quo_reg <= {quo_reg[29:0], 1'b1};
                end else begin
                    dr_reg  <= dtry;
                    quo_reg <= {quo_reg[29:0], 1'b0};
                end
                dn_reg  <= dn_reg << 1;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd30) begin
                    nrm_reg[comp_reg] <= neg_reg[comp_reg]
                        ? 32'd0 - {1'b0, quo_reg[29:0], dtry >= {1'b0, root_reg[31:0]}}
                        : {1'b0, quo_reg[29:0], dtry >= {1'b0, root_reg[31:0]}};
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_reg <= '{first_x:  tri_reg.p0.vertex_x,
                                 first_y:  tri_reg.p0.vertex_y,
                                 first_z:  tri_reg.p0.vertex_z,
                                 second_x: tri_reg.p1.vertex_x,
                                 second_y: tri_reg.p1.vertex_y,
                                 second_z: tri_reg.p1.vertex_z,
                                 third_x:  tri_reg.p2.vertex_x,
                                 third_y:  tri_reg.p2.vertex_y,
                                 third_z:  tri_reg.p2.vertex_z,
                                 normal_x: nrm_reg[0],
                                 normal_y: nrm_reg[1],
                                 normal_z: nrm_reg[2]};
                end
            end
            default: begin
                cnt_reg <= 5'd0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/triangle_assembly_unit_normal_top.sv */
// Top level of the triangle assembly unit: front end, queue, normal sequencer.
// Depends on tau_pkg, tau_front, tau_fifo, tau_back.
//
//   channel   dir   handshake           payload
//   s_        in    s_valid / s_ready   vtx_t (one vertex)
//   m_        out   m_valid / m_ready   res_t (three corners and unit normal)
//
// The first two vertices of a triple are accepted without waiting for queue
// room. The back end works through a triangle in order: the one-bit-a-cycle
// normalize shift, the 32-step square root and three divides of one load and
// 31 steps each; a zero cross product goes straight to the result.
// A two-entry triangle queue lets the front keep accepting during that work.
// Reset (aresetn low, synchronous) empties the queue and the corner count.
// A stalled result sits in the output register; the back end then waits.
`default_nettype none
module triangle_assembly_unit_normal_top
    import tau_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire vtx_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_data
);

    logic push_valid;
    logic push_ready;
    tri_t push_data;
    hs_t  q_hs;
    logic q_pop;
    tri_t q_data;

    tau_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tau_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_hs_o  (q_hs),
        .rd_ready (q_pop),
        .rd_data  (q_data)
    );

    tau_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_hs_i  (q_hs),
        .q_pop   (q_pop),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

/* rtl/core/tau_checker.sv */
// Port-level checker for the triangle assembly unit, bound to the top level.
// Depends on tau_pkg and triangle_assembly_unit_normal_top.
`default_nettype none
module tau_checker
    import tau_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire res_t m_data
);

    // Input held while waiting for a transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input dropped while waiting");

    // Result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

    // No result out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Normal components stay within one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.normal_x <= 32'sd1073741824)
                 && (m_data.normal_x >= -32'sd1073741824)
                 && (m_data.normal_y <= 32'sd1073741824)
                 && (m_data.normal_y >= -32'sd1073741824)
                 && (m_data.normal_z <= 32'sd1073741824)
                 && (m_data.normal_z >= -32'sd1073741824))
        else $error("normal component out of range");

    // Degenerate triangles give an all-zero normal, else some component is large
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.normal_x != 0 || m_data.normal_y != 0
                    || m_data.normal_z != 0)
        |-> (m_data.normal_x >= 32'sd536870912 || m_data.normal_x <= -32'sd536870912
          || m_data.normal_y >= 32'sd536870912 || m_data.normal_y <= -32'sd536870912
          || m_data.normal_z >= 32'sd536870912 || m_data.normal_z <= -32'sd536870912))
        else $error("nonzero normal is not of unit length");

endmodule

bind triangle_assembly_unit_normal_top tau_checker u_tau_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
